### hw/rtl/cars_pkg.sv
// Shared types, constants and codes for the retransmission scheduler.
package cars_pkg;

   localparam int MAX_SEGMENTS_DEF = 4096;
   localparam int CNT_W            = 13;
   localparam int SEGIDX_W         = 12;
   localparam int RETRY_W          = 8;
   localparam int FILE_W           = 32;
   localparam int PAYLOAD_W        = 16;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 32;
   localparam int REQ_DATA_W       = 32;
   localparam int RSP_DATA_W       = 80;
   localparam int RSP_PAD_W        = 7;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [FILE_W-1:0]    FILE_SIZE_RST    = 32'd0;
   localparam logic [PAYLOAD_W-1:0] PAYLOAD_SIZE_RST = 16'd1024;
   localparam logic [CNT_W-1:0]     SEG_COUNT_RST    = 13'd1;
   localparam logic [RETRY_W-1:0]   MAX_RETRIES_RST  = 8'd10;
   localparam logic [RETRY_W-1:0]   RETRY_SAT        = 8'hFF;

   localparam logic [CSR_IDX_W-1:0] CSR_FILE_SIZE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEG_COUNT    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RETRIES  = 2'd3;

   localparam logic REQ_ACK  = 1'b0;
   localparam logic REQ_SEND = 1'b1;

   typedef enum logic [1:0] {
      ST_SEND  = 2'd0,
      ST_DONE  = 2'd1,
      ST_FAIL  = 2'd2,
      ST_ACKED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_ACK  = 2'd0,
      KIND_DONE = 2'd1,
      KIND_SEND = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      BK_CLEAR = 2'd0,
      BK_IDLE  = 2'd1,
      BK_EXEC  = 2'd2
   } back_state_type;

   typedef struct packed {
      logic [FILE_W-1:0]    file_size;
      logic [PAYLOAD_W-1:0] payload_size;
      logic [CNT_W-1:0]     segment_count;
      logic [RETRY_W-1:0]   max_retries;
   } cfg_type;

   typedef struct packed {
      kind_type         kind;
      logic [CNT_W-1:0] seg;
      logic [CNT_W-1:0] acked;
   } entry_type;

endpackage

### hw/rtl/cars_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cars_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/cars_front.sv
// Front end: accepts request words, tracks the ack pointer and picks the next segment.
module cars_front #(
   parameter int MAX_SEGMENTS = cars_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [cars_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tuser,
   input  cars_pkg::cfg_type                   cfg,
   input  logic                                clear_done,
   output logic                                push_valid,
   input  logic                                push_ready,
   output cars_pkg::entry_type                 push_entry
);

   logic [cars_pkg::CNT_W-1:0] acked_ff, acked_in;
   logic [cars_pkg::CNT_W-1:0] scan_ff, scan_in;
   logic [cars_pkg::CNT_W-1:0] cnt;
   logic [cars_pkg::CNT_W-1:0] seg;
   logic                       accept;

   assign req_tready = clear_done & push_ready;
   assign accept     = req_tvalid & req_tready;
   assign push_valid = accept;

   always_comb begin
      cnt = (32'(cfg.segment_count) > 32'(MAX_SEGMENTS)) ?
            cars_pkg::CNT_W'(MAX_SEGMENTS) : cfg.segment_count;
      seg = ((scan_ff < acked_ff) || (scan_ff >= cnt)) ? acked_ff : scan_ff;
      acked_in = acked_ff;
      scan_in  = scan_ff;
      push_entry.kind  = cars_pkg::KIND_ACK;
      push_entry.seg   = '0;
      if (req_tuser == cars_pkg::REQ_ACK) begin
         if (req_tdata >= 32'(cnt)) begin
            if (cnt > acked_ff) begin
               acked_in = cnt;
            end
         end else if (req_tdata[cars_pkg::CNT_W-1:0] > acked_ff) begin
            // below the count, so the low bits carry the whole value
            acked_in = req_tdata[cars_pkg::CNT_W-1:0];
         end
      end else if (acked_ff >= cnt) begin
         push_entry.kind = cars_pkg::KIND_DONE;
      end else begin
         push_entry.kind = cars_pkg::KIND_SEND;
         push_entry.seg  = seg;
         scan_in         = seg + 1'b1;
      end
      push_entry.acked = acked_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acked_ff <= '0;
         scan_ff  <= '0;
      end else if (accept) begin
         acked_ff <= acked_in;
         scan_ff  <= scan_in;
      end
   end

endmodule

### hw/rtl/cars_fifo.sv
// Short word queue between front and back end.
module cars_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  cars_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output cars_pkg::entry_type pop_entry
);

   localparam int PTR_W = $clog2(cars_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(cars_pkg::QUEUE_DEPTH + 1);

   cars_pkg::entry_type slot_ff [cars_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(cars_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(cars_pkg::QUEUE_DEPTH - 1)) ? '0 :
                         wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(cars_pkg::QUEUE_DEPTH - 1)) ? '0 :
                         rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### hw/rtl/cars_back.sv
// Back end: retry table clear and update, segment offset and length, result register.
module cars_back #(
   parameter int MAX_SEGMENTS = cars_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cars_pkg::cfg_type               cfg,
   input  logic                            pop_valid,
   output logic                            pop_ready,
   input  cars_pkg::entry_type             pop_entry,
   output logic                            clear_done,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cars_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]                      rsp_tuser
);

   localparam int SEG_W = $clog2(MAX_SEGMENTS);

   cars_pkg::back_state_type state_ff, state_in;

   logic [SEG_W-1:0]                 clr_ff, clr_in;
   cars_pkg::entry_type              entry_ff;
   logic [cars_pkg::FILE_W-1:0]      off_ff, off_in;
   logic                             failed_ff, failed_in;
   logic [cars_pkg::CNT_W-1:0]       frozen_ff, frozen_in;
   logic                             out_valid_ff;
   cars_pkg::status_type             out_status_ff, res_status;
   logic [cars_pkg::SEGIDX_W-1:0]    out_seg_ff, res_seg;
   logic [cars_pkg::FILE_W-1:0]      out_off_ff, res_off;
   logic [cars_pkg::PAYLOAD_W-1:0]   out_len_ff, res_len;
   logic [cars_pkg::CNT_W-1:0]       out_acked_ff, res_acked;

   logic                             out_free, take, fire, over;
   logic                             ram_wen, ram_ren;
   logic [SEG_W-1:0]                 ram_waddr, ram_raddr;
   logic [cars_pkg::RETRY_W-1:0]     ram_wdata, ram_rdata, retry_inc;
   logic [cars_pkg::FILE_W:0]        end_sum;

   cars_ram #(
      .WIDTH(cars_pkg::RETRY_W),
      .DEPTH(MAX_SEGMENTS)
   ) u_retry_ram (
      .clock  (clock),
      .wr_en  (ram_wen),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_ren),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   assign clear_done = state_ff != cars_pkg::BK_CLEAR;
   assign over       = ram_rdata >= cfg.max_retries;
   assign retry_inc  = (ram_rdata == cars_pkg::RETRY_SAT) ? ram_rdata : ram_rdata + 1'b1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cars_pkg::BK_CLEAR: begin
            if (clr_ff == SEG_W'(MAX_SEGMENTS - 1)) begin
               state_in = cars_pkg::BK_IDLE;
            end
         end
         cars_pkg::BK_IDLE: begin
            if (pop_valid) begin
               state_in = cars_pkg::BK_EXEC;
            end
         end
         cars_pkg::BK_EXEC: begin
            if (out_free) begin
               state_in = cars_pkg::BK_IDLE;
            end
         end
         default: state_in = cars_pkg::BK_CLEAR;
      endcase
   end

   always_comb begin
      pop_ready = 1'b0;
      take      = 1'b0;
      fire      = 1'b0;
      ram_wen   = 1'b0;
      ram_ren   = 1'b0;
      ram_waddr = clr_ff;
      ram_wdata = '0;
      ram_raddr = SEG_W'(pop_entry.seg);
      clr_in    = clr_ff;
      unique case (state_ff)
         cars_pkg::BK_CLEAR: begin
            ram_wen = 1'b1;
            clr_in  = clr_ff + 1'b1;
         end
         cars_pkg::BK_IDLE: begin
            pop_ready = 1'b1;
            take      = pop_valid;
            ram_ren   = pop_valid;
         end
         cars_pkg::BK_EXEC: begin
            fire      = out_free;
            ram_waddr = SEG_W'(entry_ff.seg);
            ram_wdata = retry_inc;
            ram_wen   = out_free && !failed_ff && !over &&
                        (entry_ff.kind == cars_pkg::KIND_SEND);
         end
         default: begin
            clr_in = '0;
         end
      endcase
   end

   // offset product registered ahead of the length compare
   assign off_in  = 32'(pop_entry.seg) * 32'(cfg.payload_size);
   assign end_sum = {1'b0, off_ff} + 33'(cfg.payload_size);

   always_comb begin
      res_status = cars_pkg::ST_ACKED;
      res_seg    = '0;
      res_off    = '0;
      res_len    = '0;
      res_acked  = entry_ff.acked;
      failed_in  = failed_ff;
      frozen_in  = frozen_ff;
      if (failed_ff) begin
         res_status = cars_pkg::ST_FAIL;
         res_acked  = frozen_ff;
      end else begin
         case (entry_ff.kind)
            cars_pkg::KIND_DONE: res_status = cars_pkg::ST_DONE;
            cars_pkg::KIND_SEND: begin
               res_seg = cars_pkg::SEGIDX_W'(entry_ff.seg);
               if (over) begin
                  res_status = cars_pkg::ST_FAIL;
                  failed_in  = 1'b1;
                  frozen_in  = entry_ff.acked;
               end else begin
                  res_status = cars_pkg::ST_SEND;
                  res_off    = off_ff;
                  if (end_sum > 33'(cfg.file_size)) begin
                     res_len = (off_ff >= cfg.file_size) ? '0 :
                               cars_pkg::PAYLOAD_W'(cfg.file_size - off_ff);
                  end else begin
                     res_len = cfg.payload_size;
                  end
               end
            end
            default: res_status = cars_pkg::ST_ACKED;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cars_pkg::BK_CLEAR;
         clr_ff       <= '0;
         failed_ff    <= 1'b0;
         frozen_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (fire) begin
            failed_ff    <= failed_in;
            frozen_ff    <= frozen_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         entry_ff <= pop_entry;
         off_ff   <= off_in;
      end
      if (fire) begin
         out_status_ff <= res_status;
         out_seg_ff    <= res_seg;
         out_off_ff    <= res_off;
         out_len_ff    <= res_len;
         out_acked_ff  <= res_acked;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {{cars_pkg::RSP_PAD_W{1'b0}}, out_acked_ff, out_len_ff,
                        out_off_ff, out_seg_ff};

endmodule

### hw/rtl/cumulative_ack_retransmit_scheduler.sv
// Top level of the cumulative-ack retransmission scheduler.
// Each request word is an acknowledgement or a send-slot request and yields exactly one
// response word. The front end takes one word per cycle, while the queue has room, into
// a two-word queue. The back end reads the retry table, then compares and writes back
// once the response register is free; it takes no new word until done with the last.
// After reset it clears the retry table, one entry per cycle; req_tready stays low
// meanwhile. Once a segment hits its retry limit all later responses fail until reset.
module cumulative_ack_retransmit_scheduler #(
   parameter int MAX_SEGMENTS = cars_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [cars_pkg::REQ_DATA_W-1:0]  req_tdata,  // ack_seq
   input  logic                             req_tuser,  // req_type
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // segment_index, byte_offset, byte_length, acked_count, zero fill
   output logic [cars_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [1:0]                       rsp_tuser,  // status
   input  logic                             csr_wen,
   input  logic [cars_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cars_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   cars_pkg::cfg_type   cfg_ff;
   cars_pkg::entry_type push_entry, pop_entry;
   logic                push_valid, push_ready, pop_valid, pop_ready, clear_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.file_size     <= cars_pkg::FILE_SIZE_RST;
         cfg_ff.payload_size  <= cars_pkg::PAYLOAD_SIZE_RST;
         cfg_ff.segment_count <= cars_pkg::SEG_COUNT_RST;
         cfg_ff.max_retries   <= cars_pkg::MAX_RETRIES_RST;
      end else if (csr_wen) begin
         unique case (csr_index)
            cars_pkg::CSR_FILE_SIZE:    cfg_ff.file_size     <= csr_wdata;
            cars_pkg::CSR_PAYLOAD_SIZE: cfg_ff.payload_size  <= csr_wdata[15:0];
            cars_pkg::CSR_SEG_COUNT:    cfg_ff.segment_count <= csr_wdata[12:0];
            cars_pkg::CSR_MAX_RETRIES:  cfg_ff.max_retries   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   cars_front #(
      .MAX_SEGMENTS(MAX_SEGMENTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cfg       (cfg_ff),
      .clear_done(clear_done),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_entry(push_entry)
   );

   cars_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_entry(push_entry),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry)
   );

   cars_back #(
      .MAX_SEGMENTS(MAX_SEGMENTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .clear_done(clear_done),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

### hw/rtl/cars_checker.sv
// Port-level checks on the scheduler's response stream, bound to the top level.
module cars_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [cars_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]                      rsp_tuser
);

   logic                       failed_seen_ff;
   logic [cars_pkg::CNT_W-1:0] last_acked_ff;
   logic                       rsp_take;

   assign rsp_take = rsp_tvalid & rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         failed_seen_ff <= 1'b0;
         last_acked_ff  <= '0;
      end else if (rsp_take) begin
         last_acked_ff <= rsp_tdata[72:60];
         if (rsp_tuser == cars_pkg::ST_FAIL) begin
            failed_seen_ff <= 1'b1;
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response word changed while stalled");

   a_fail_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && failed_seen_ff |-> rsp_tuser == cars_pkg::ST_FAIL)
      else $error("response after failure is not a failure");

   a_no_span: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != cars_pkg::ST_SEND |-> rsp_tdata[59:12] == '0)
      else $error("offset or length set on a non-send response");

   a_ack_mono: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> rsp_tdata[72:60] >= last_acked_ff)
      else $error("acked count went backwards");

endmodule

bind cumulative_ack_retransmit_scheduler cars_checker u_cars_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);
